// File: rtl/ctsb_pkg.sv
`default_nettype none
package ctsb_pkg;

  localparam int ReplyDepthDefault = 16;
  localparam int QDepth = 4;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_REPLY = 1'b1;

  localparam logic KIND_BUS = 1'b0;
  localparam logic KIND_FB  = 1'b1;

  localparam logic [4:0] CLS_READ  = 5'd0;
  localparam logic [4:0] CLS_WRITE = 5'd1;
  localparam logic [4:0] CLS_MOVE  = 5'd2;

  localparam logic [7:0] SUB_INFO       = 8'h00;
  localparam logic [7:0] SUB_ID         = 8'h01;
  localparam logic [7:0] SUB_OFFSET     = 8'h02;
  localparam logic [7:0] SUB_ANGLE_LOW  = 8'h03;
  localparam logic [7:0] SUB_ANGLE_HIGH = 8'h04;
  localparam logic [7:0] SUB_POS        = 8'h05;
  localparam logic [7:0] SUB_VOLT_LOW   = 8'h06;
  localparam logic [7:0] SUB_VOLT_HIGH  = 8'h07;
  localparam logic [7:0] SUB_VIN        = 8'h08;
  localparam logic [7:0] SUB_ERR        = 8'h09;
  localparam logic [7:0] SUB_TEMP       = 8'h10;
  localparam logic [7:0] SUB_MODE       = 8'h11;

  localparam logic [7:0] CMD_MOVE         = 8'd1;
  localparam logic [7:0] CMD_ID_WRITE     = 8'd13;
  localparam logic [7:0] CMD_ID_READ      = 8'd14;
  localparam logic [7:0] CMD_OFFSET_ADJ   = 8'd17;
  localparam logic [7:0] CMD_OFFSET_WRITE = 8'd18;
  localparam logic [7:0] CMD_OFFSET_READ  = 8'd19;
  localparam logic [7:0] CMD_ANGLE_WRITE  = 8'd20;
  localparam logic [7:0] CMD_ANGLE_READ   = 8'd21;
  localparam logic [7:0] CMD_VOLT_WRITE   = 8'd22;
  localparam logic [7:0] CMD_VOLT_READ    = 8'd23;
  localparam logic [7:0] CMD_TEMP_READ    = 8'd26;
  localparam logic [7:0] CMD_VIN_READ     = 8'd27;
  localparam logic [7:0] CMD_POS_READ     = 8'd28;
  localparam logic [7:0] CMD_MODE_WRITE   = 8'd29;
  localparam logic [7:0] CMD_MODE_READ    = 8'd30;
  localparam logic [7:0] CMD_ERR_READ     = 8'd36;

  localparam logic [7:0]  SYNC_BYTE    = 8'h55;
  localparam logic [7:0]  BROADCAST_ID = 8'd254;
  localparam logic [7:0]  NODE_TAG_RST = 8'd4;
  localparam logic [7:0]  SERVO_ID_RST = 8'd254;
  localparam logic [15:0] ANGLE_LO_RST = 16'd0;
  localparam logic [15:0] ANGLE_HI_RST = 16'd1000;
  localparam logic [15:0] VOLT_LO_RST  = 16'd4500;
  localparam logic [15:0] VOLT_HI_RST  = 16'd12000;
  localparam logic [15:0] SPIN_RST     = 16'd500;

  typedef enum logic [1:0] {PH_PKT1, PH_PKT2, PH_FB} phase_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  cmd;
    logic [3:0]  exp_len;
    logic [1:0]  flen;
  } rd_info_t;

  typedef struct packed {
    logic        has_pkt1;
    logic        has_pkt2;
    logic [7:0]  pkt_id;
    logic [7:0]  pkt_cmd;
    logic [2:0]  pkt_np;
    logic [31:0] pkt_prm;
    logic        has_fb;
    logic [4:0]  fb_class;
    logic [7:0]  fb_master;
    logic [7:0]  fb_node;
    logic [63:0] fb_payload;
  } job_t;

  function automatic rd_info_t read_info(input logic [7:0] sub);
    rd_info_t r;
    r = '0;
    r.ok = 1'b1;
    unique case (sub)
      SUB_ID:         begin r.cmd = CMD_ID_READ;     r.exp_len = 4'd7;  r.flen = 2'd1; end
      SUB_OFFSET:     begin r.cmd = CMD_OFFSET_READ; r.exp_len = 4'd7;  r.flen = 2'd1; end
      SUB_ANGLE_LOW:  begin r.cmd = CMD_ANGLE_READ;  r.exp_len = 4'd10; r.flen = 2'd2; end
      SUB_ANGLE_HIGH: begin r.cmd = CMD_ANGLE_READ;  r.exp_len = 4'd10; r.flen = 2'd2; end
      SUB_POS:        begin r.cmd = CMD_POS_READ;    r.exp_len = 4'd8;  r.flen = 2'd2; end
      SUB_VOLT_LOW:   begin r.cmd = CMD_VOLT_READ;   r.exp_len = 4'd10; r.flen = 2'd2; end
      SUB_VOLT_HIGH:  begin r.cmd = CMD_VOLT_READ;   r.exp_len = 4'd10; r.flen = 2'd2; end
      SUB_VIN:        begin r.cmd = CMD_VIN_READ;    r.exp_len = 4'd8;  r.flen = 2'd2; end
      SUB_ERR:        begin r.cmd = CMD_ERR_READ;    r.exp_len = 4'd7;  r.flen = 2'd1; end
      SUB_TEMP:       begin r.cmd = CMD_TEMP_READ;   r.exp_len = 4'd7;  r.flen = 2'd1; end
      SUB_MODE:       begin r.cmd = CMD_MODE_READ;   r.exp_len = 4'd10; r.flen = 2'd1; end
      default:        r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ctsb_ifs.sv
`default_nettype none
interface ctsb_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [4:0]  frame_class;
  logic [7:0]  host_id;
  logic [7:0]  dest_id;
  logic [63:0] frame_data;
  logic [7:0]  reply_byte;
  modport source (output valid, req_type, frame_class, host_id, dest_id, frame_data,
                  reply_byte, input ready);
  modport sink (input valid, req_type, frame_class, host_id, dest_id, frame_data,
                reply_byte, output ready);
endinterface

interface ctsb_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  bus_byte;
  logic [4:0]  fb_class;
  logic [7:0]  fb_master;
  logic [7:0]  fb_node;
  logic [63:0] fb_payload;
  logic        last;
  modport source (output valid, out_kind, bus_byte, fb_class, fb_master, fb_node,
                  fb_payload, last, input ready);
  modport sink (input valid, out_kind, bus_byte, fb_class, fb_master, fb_node,
                fb_payload, last, output ready);
endinterface
`default_nettype wire

// File: rtl/can_to_servo_bus_bridge.sv
// Channel   Dir  Beat
// in_ch     in   CAN command frame or one servo reply byte
// out_ch    out  one servo bus byte or one CAN feedback frame, last on the final one
//
// The front decodes one input beat per cycle while the queue has room and updates all stored values at once.
// Each beat that yields results leaves a job in a four-deep queue.
// The back sends one result per cycle while the output is not stalled.
// Input stalls only when the queue is full; output stalls hold the output register.
// Reset is synchronous and restores all stored values; the reply bytes need no clearing.
`default_nettype none
module can_to_servo_bus_bridge
  import ctsb_pkg::*;
#(
  parameter int REPLY_DEPTH = ReplyDepthDefault
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ctsb_in_if.sink    in_ch,
  ctsb_out_if.source out_ch
);

  logic q_not_full, q_push, q_valid, q_pop;
  job_t push_job, head_job;

  ctsb_front #(.REPLY_DEPTH(REPLY_DEPTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_not_full),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  ctsb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  ctsb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> q_not_full)
    else $error("job pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("job popped from an empty queue");

  a_job_content: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (push_job.has_pkt1 || push_job.has_fb))
    else $error("job pushed with no result");

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

// File: rtl/ctsb_front.sv
`default_nettype none
module ctsb_front
  import ctsb_pkg::*;
#(
  parameter int REPLY_DEPTH = ReplyDepthDefault
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ctsb_in_if.sink    in_ch,
  input  wire logic  q_ready,
  output logic       q_push,
  output job_t       q_job
);

  localparam int IdxW = $clog2(REPLY_DEPTH);

  logic [7:0]  node_tag_r, node_tag_nxt;
  logic [7:0]  servo_id_r, servo_id_nxt;
  logic [15:0] angle_low_r, angle_low_nxt, angle_high_r, angle_high_nxt;
  logic [15:0] volt_low_r, volt_low_nxt, volt_high_r, volt_high_nxt;
  logic [15:0] spin_rate_r, spin_rate_nxt;
  logic [7:0]  pend_code_r, pend_code_nxt;
  logic [4:0]  pend_class_r, pend_class_nxt;
  logic [7:0]  pend_master_r, pend_master_nxt;
  logic [7:0]  pend_node_r, pend_node_nxt;
  logic [3:0]  reply_count_r, reply_count_nxt;
  logic [3:0]  reply_exp_r, reply_exp_nxt;
  logic [7:0]  reply_store_r [REPLY_DEPTH];
  logic        store_en;

  logic        accept;
  logic [7:0]  d [8];
  logic [15:0] v;
  logic [15:0] a_lo, a_hi, vo_lo, vo_hi;
  rd_info_t    fri, pri;
  logic [3:0]  cnt_inc;
  logic [7:0]  b6, b7;
  job_t        job;

  assign in_ch.ready = q_ready;
  assign accept = in_ch.valid && q_ready;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      d[i] = in_ch.frame_data[8*i +: 8];
    end
    v   = {d[7], d[6]};
    fri = read_info(d[0]);
    pri = read_info(pend_code_r);
    cnt_inc = reply_count_r + 4'd1;
    a_lo  = (v >= angle_high_r) ? angle_high_r - 16'd1 : v;
    a_hi  = (angle_low_r >= v) ? angle_low_r + 16'd1 : v;
    vo_lo = (v >= volt_high_r) ? volt_high_r - 16'd1 : v;
    vo_hi = (volt_low_r >= v) ? volt_low_r + 16'd1 : v;

    node_tag_nxt    = node_tag_r;
    servo_id_nxt    = servo_id_r;
    angle_low_nxt   = angle_low_r;
    angle_high_nxt  = angle_high_r;
    volt_low_nxt    = volt_low_r;
    volt_high_nxt   = volt_high_r;
    spin_rate_nxt   = spin_rate_r;
    pend_code_nxt   = pend_code_r;
    pend_class_nxt  = pend_class_r;
    pend_master_nxt = pend_master_r;
    pend_node_nxt   = pend_node_r;
    reply_count_nxt = reply_count_r;
    reply_exp_nxt   = reply_exp_r;
    store_en        = 1'b0;
    b6              = 8'd0;
    b7              = 8'd0;
    job             = '0;
    job.pkt_id      = servo_id_r;
    q_push          = 1'b0;

    if (accept) begin
      if (in_ch.req_type == REQ_REPLY) begin
        if (pend_code_r != 8'd0) begin
          store_en        = ({1'b0, reply_count_r} < 5'(REPLY_DEPTH));
          reply_count_nxt = cnt_inc;
          if (cnt_inc >= reply_exp_r) begin
            b7 = reply_store_r[5];
            case (pend_code_r)
              SUB_ID: servo_id_nxt = reply_store_r[5];
              SUB_ANGLE_LOW, SUB_VOLT_LOW, SUB_POS, SUB_VIN: begin
                b6 = reply_store_r[5];
                b7 = reply_store_r[6];
              end
              SUB_ANGLE_HIGH, SUB_VOLT_HIGH: begin
                b6 = reply_store_r[7];
                b7 = reply_store_r[8];
              end
              SUB_MODE: spin_rate_nxt = {reply_store_r[8], reply_store_r[7]};
              default: ;
            endcase
            if (pend_code_r == SUB_ANGLE_LOW || pend_code_r == SUB_ANGLE_HIGH) begin
              angle_low_nxt  = {reply_store_r[6], reply_store_r[5]};
              angle_high_nxt = {reply_store_r[8], reply_store_r[7]};
            end
            if (pend_code_r == SUB_VOLT_LOW || pend_code_r == SUB_VOLT_HIGH) begin
              volt_low_nxt  = {reply_store_r[6], reply_store_r[5]};
              volt_high_nxt = {reply_store_r[8], reply_store_r[7]};
            end
            job.has_fb     = 1'b1;
            job.fb_class   = pend_class_r;
            job.fb_master  = pend_master_r;
            job.fb_node    = pend_node_r;
            job.fb_payload = {b7, b6, 32'd0, 6'd0, pri.flen, pend_code_r};
            q_push          = 1'b1;
            pend_code_nxt   = 8'd0;
            reply_count_nxt = 4'd0;
            reply_exp_nxt   = 4'd0;
          end
        end
      end else if (pend_code_r == 8'd0 && in_ch.dest_id == node_tag_r) begin
        q_push        = 1'b1;
        job.has_fb    = 1'b1;
        job.fb_class  = in_ch.frame_class;
        job.fb_master = in_ch.host_id;
        case (in_ch.frame_class)
          CLS_READ: begin
            if (d[0] == SUB_INFO) begin
              job.fb_payload = {node_tag_r, 40'd0, 8'd1, 8'd0};
            end else if (fri.ok) begin
              job.has_fb      = 1'b0;
              job.has_pkt1    = 1'b1;
              job.pkt_id      = (d[0] == SUB_ID) ? BROADCAST_ID : servo_id_r;
              job.pkt_cmd     = fri.cmd;
              pend_code_nxt   = d[0];
              pend_class_nxt  = in_ch.frame_class;
              pend_master_nxt = in_ch.host_id;
              pend_node_nxt   = node_tag_r;
              reply_count_nxt = 4'd0;
              reply_exp_nxt   = fri.exp_len;
            end
          end
          CLS_WRITE: begin
            job.fb_payload = in_ch.frame_data;
            job.pkt_np     = 3'd4;
            case (d[0])
              SUB_INFO: node_tag_nxt = d[7];
              SUB_ID: begin
                job.has_pkt1 = 1'b1;
                job.pkt_cmd  = CMD_ID_WRITE;
                job.pkt_np   = 3'd1;
                job.pkt_prm  = {24'd0, d[7]};
                servo_id_nxt = d[7];
              end
              SUB_OFFSET: begin
                job.has_pkt1 = 1'b1;
                job.has_pkt2 = 1'b1;
                job.pkt_cmd  = CMD_OFFSET_ADJ;
                job.pkt_np   = 3'd1;
                job.pkt_prm  = {24'd0, d[7]};
              end
              SUB_ANGLE_LOW: begin
                job.has_pkt1  = 1'b1;
                job.pkt_cmd   = CMD_ANGLE_WRITE;
                job.pkt_prm   = {angle_high_r, a_lo};
                angle_low_nxt = a_lo;
              end
              SUB_ANGLE_HIGH: begin
                job.has_pkt1   = 1'b1;
                job.pkt_cmd    = CMD_ANGLE_WRITE;
                job.pkt_prm    = {a_hi, angle_low_r};
                angle_high_nxt = a_hi;
              end
              SUB_VOLT_LOW: begin
                job.has_pkt1 = 1'b1;
                job.pkt_cmd  = CMD_VOLT_WRITE;
                job.pkt_prm  = {volt_high_r, vo_lo};
                volt_low_nxt = vo_lo;
              end
              SUB_VOLT_HIGH: begin
                job.has_pkt1  = 1'b1;
                job.pkt_cmd   = CMD_VOLT_WRITE;
                job.pkt_prm   = {vo_hi, volt_low_r};
                volt_high_nxt = vo_hi;
              end
              SUB_MODE: begin
                job.has_pkt1 = 1'b1;
                job.pkt_cmd  = CMD_MODE_WRITE;
                job.pkt_prm  = {spin_rate_r, 8'd0, d[7]};
              end
              default: job.fb_payload = 64'd0;
            endcase
          end
          CLS_MOVE: begin
            job.has_pkt1 = 1'b1;
            job.pkt_cmd  = CMD_MOVE;
            job.pkt_np   = 3'd4;
            job.pkt_prm  = {d[5], d[4], d[1], d[0]};
          end
          default: ;
        endcase
        job.fb_node = node_tag_nxt;
      end
    end
    q_job = job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_tag_r    <= NODE_TAG_RST;
      servo_id_r    <= SERVO_ID_RST;
      angle_low_r   <= ANGLE_LO_RST;
      angle_high_r  <= ANGLE_HI_RST;
      volt_low_r    <= VOLT_LO_RST;
      volt_high_r   <= VOLT_HI_RST;
      spin_rate_r   <= SPIN_RST;
      pend_code_r   <= 8'd0;
      pend_class_r  <= 5'd0;
      pend_master_r <= 8'd0;
      pend_node_r   <= 8'd0;
      reply_count_r <= 4'd0;
      reply_exp_r   <= 4'd0;
    end else begin
      node_tag_r    <= node_tag_nxt;
      servo_id_r    <= servo_id_nxt;
      angle_low_r   <= angle_low_nxt;
      angle_high_r  <= angle_high_nxt;
      volt_low_r    <= volt_low_nxt;
      volt_high_r   <= volt_high_nxt;
      spin_rate_r   <= spin_rate_nxt;
      pend_code_r   <= pend_code_nxt;
      pend_class_r  <= pend_class_nxt;
      pend_master_r <= pend_master_nxt;
      pend_node_r   <= pend_node_nxt;
      reply_count_r <= reply_count_nxt;
      reply_exp_r   <= reply_exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      reply_store_r[reply_count_r[IdxW-1:0]] <= in_ch.reply_byte;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ctsb_queue.sv
`default_nettype none
module ctsb_queue
  import ctsb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  output logic      not_full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  localparam int PtrW = $clog2(QDepth);

  job_t            slot_r [QDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]   count_r;

  assign not_full   = (count_r != (PtrW+1)'(QDepth));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ctsb_back.sv
`default_nettype none
module ctsb_back
  import ctsb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  job_t       q_job,
  output logic       q_pop,
  ctsb_out_if.source out_ch
);

  phase_t      phase_r, phase_nxt, cur;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [2:0]  np;
  logic [7:0]  cmd, bval;
  logic [3:0]  chk_pos;
  logic [1:0]  pidx;
  logic        seg_end, done, emit;

  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  bus_byte_r;
  logic [4:0]  fb_class_r;
  logic [7:0]  fb_master_r, fb_node_r;
  logic [63:0] fb_payload_r;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PKT1;
      idx_r   <= 4'd0;
      sum_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_comb begin
    cur = phase_r;
    if (phase_r == PH_PKT1 && !q_job.has_pkt1) begin
      cur = PH_FB;
    end
    np      = (cur == PH_PKT2) ? 3'd0 : q_job.pkt_np;
    cmd     = (cur == PH_PKT2) ? CMD_OFFSET_WRITE : q_job.pkt_cmd;
    chk_pos = 4'd5 + {1'b0, np};
    pidx    = 2'(idx_r - 4'd5);
    if (idx_r < 4'd2) begin
      bval = SYNC_BYTE;
    end else if (idx_r == 4'd2) begin
      bval = q_job.pkt_id;
    end else if (idx_r == 4'd3) begin
      bval = {5'd0, np} + 8'd3;
    end else if (idx_r == 4'd4) begin
      bval = cmd;
    end else if (idx_r == chk_pos) begin
      bval = ~sum_r;
    end else begin
      bval = q_job.pkt_prm[8*pidx +: 8];
    end

    seg_end = (cur == PH_FB) || (idx_r == chk_pos);
    done    = 1'b1;
    phase_nxt = phase_r;
    unique case (cur)
      PH_PKT1: begin
        if (q_job.has_pkt2) begin
          phase_nxt = PH_PKT2;
          done      = 1'b0;
        end else if (q_job.has_fb) begin
          phase_nxt = PH_FB;
          done      = 1'b0;
        end
      end
      PH_PKT2: begin
        if (q_job.has_fb) begin
          phase_nxt = PH_FB;
          done      = 1'b0;
        end
      end
      PH_FB: ;
      default: ;
    endcase

    emit    = q_valid && (!out_valid_r || out_ch.ready);
    q_pop   = 1'b0;
    idx_nxt = idx_r;
    sum_nxt = sum_r;
    if (!emit) begin
      phase_nxt = phase_r;
    end else if (seg_end) begin
      idx_nxt = 4'd0;
      sum_nxt = 8'd0;
      if (done) begin
        phase_nxt = PH_PKT1;
        q_pop     = 1'b1;
      end
    end else begin
      phase_nxt = phase_r;
      idx_nxt   = idx_r + 4'd1;
      sum_nxt   = (idx_r < 4'd2) ? 8'd0 : sum_r + bval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      last_r <= seg_end && done;
      if (cur == PH_FB) begin
        out_kind_r   <= KIND_FB;
        bus_byte_r   <= 8'd0;
        fb_class_r   <= q_job.fb_class;
        fb_master_r  <= q_job.fb_master;
        fb_node_r    <= q_job.fb_node;
        fb_payload_r <= q_job.fb_payload;
      end else begin
        out_kind_r   <= KIND_BUS;
        bus_byte_r   <= bval;
        fb_class_r   <= 5'd0;
        fb_master_r  <= 8'd0;
        fb_node_r    <= 8'd0;
        fb_payload_r <= 64'd0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_kind   = out_kind_r;
  assign out_ch.bus_byte   = bus_byte_r;
  assign out_ch.fb_class   = fb_class_r;
  assign out_ch.fb_master  = fb_master_r;
  assign out_ch.fb_node    = fb_node_r;
  assign out_ch.fb_payload = fb_payload_r;
  assign out_ch.last       = last_r;

endmodule
`default_nettype wire
